// File: sv/rhc_pkg.sv
// rhc_pkg: types and constants shared by the RGB to HSL converter.
// No dependencies.
`default_nettype none

package rhc_pkg;

    localparam int unsigned DIV_STEPS = 16;

    localparam logic [15:0] HUE_TURN = 16'd23040;

    typedef struct packed {
        logic [7:0] red_value;
        logic [7:0] green_value;
        logic [7:0] blue_value;
    } rhc_in_t;

    typedef struct packed {
        logic [14:0] hue_angle;
        logic [12:0] saturation_level;
        logic [8:0]  lightness_sum;
    } rhc_out_t;

    // partial remainder, divisor and a shift word that feeds dividend bits out
    // at the top and takes quotient bits in at the bottom
    typedef struct packed {
        logic [7:0]  hue_rem;
        logic [7:0]  hue_div;
        logic [15:0] hue_bits;
        logic [7:0]  sat_rem;
        logic [7:0]  sat_div;
        logic [15:0] sat_bits;
        logic [8:0]  sum;
        logic        grey;
    } rhc_div_t;

endpackage

`default_nettype wire

// File: sv/rhc_prep.sv
// rhc_prep: first stage; max/min, sextant numerator and divider setup.
// Depends on rhc_pkg.
`default_nettype none

module rhc_prep (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  up_valid,
    output logic                 up_stall,
    input  rhc_pkg::rhc_in_t     up_word,
    output logic                 dn_valid,
    input  wire                  dn_stall,
    output rhc_pkg::rhc_div_t    dn_word
);
    import rhc_pkg::*;

    logic       valid_reg;
    rhc_div_t   word_reg;
    rhc_div_t   word_next;

    logic [7:0]  r, g, b, hi, lo, delta;
    logic [8:0]  sum, den;
    logic [10:0] numer;
    logic [23:0] prod;
    logic        red_max, green_max;
    logic [20:0] sat_dvd;

    always_comb
    begin
        r = up_word.red_value;
        g = up_word.green_value;
        b = up_word.blue_value;
        red_max   = (r >= g) && (r >= b);
        green_max = !red_max && (g >= b);
        if (red_max)
            hi = r;
        else if (green_max)
            hi = g;
        else
            hi = b;
        if (r <= g && r <= b)
            lo = r;
        else if (g <= b)
            lo = g;
        else
            lo = b;
        delta = hi - lo;
        sum   = {1'b0, hi} + {1'b0, lo};
        den   = (sum > 9'd255) ? (9'd510 - sum) : sum;
        if (red_max)
        begin
            if (g < b)
                numer = (11'(delta) << 2) + (11'(delta) << 1) - 11'(b - g);
            else
                numer = 11'(g - b);
        end
        else if (green_max)
            numer = (11'(delta) << 1) + 11'(b) - 11'(r);
        else
            numer = (11'(delta) << 2) + 11'(r) - 11'(g);
        // 7680 = 8192 - 512
        prod    = (24'(numer) << 13) - (24'(numer) << 9);
        sat_dvd = {delta, 13'd0};

        word_next.hue_rem  = prod[23:16];
        word_next.hue_div  = delta;
        word_next.hue_bits = prod[15:0];
        word_next.sat_rem  = {3'd0, sat_dvd[20:16]};
        word_next.sat_div  = den[7:0];
        word_next.sat_bits = sat_dvd[15:0];
        word_next.sum      = sum;
        word_next.grey     = (delta == 8'd0);
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

// File: sv/rhc_div_cell.sv
// rhc_div_cell: one restoring-division step for hue and saturation.
// Depends on rhc_pkg.
`default_nettype none

module rhc_div_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  up_valid,
    output logic                 up_stall,
    input  rhc_pkg::rhc_div_t    up_word,
    output logic                 dn_valid,
    input  wire                  dn_stall,
    output rhc_pkg::rhc_div_t    dn_word
);
    import rhc_pkg::*;

    logic       valid_reg;
    rhc_div_t   word_reg;
    rhc_div_t   word_next;
    logic [8:0] hue_trial, sat_trial;
    logic       hue_ge, sat_ge;

    always_comb
    begin
        hue_trial = {up_word.hue_rem, up_word.hue_bits[15]};
        sat_trial = {up_word.sat_rem, up_word.sat_bits[15]};
        hue_ge    = hue_trial >= {1'b0, up_word.hue_div};
        sat_ge    = sat_trial >= {1'b0, up_word.sat_div};
        word_next = up_word;
        word_next.hue_rem  = hue_ge ? 8'(hue_trial - {1'b0, up_word.hue_div})
                                    : hue_trial[7:0];
        word_next.sat_rem  = sat_ge ? 8'(sat_trial - {1'b0, up_word.sat_div})
                                    : sat_trial[7:0];
        word_next.hue_bits = {up_word.hue_bits[14:0], hue_ge};
        word_next.sat_bits = {up_word.sat_bits[14:0], sat_ge};
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

// File: sv/rhc_round.sv
// rhc_round: output stage; rounds quotients half up, wraps the hue, zeroes grey pixels.
// Depends on rhc_pkg.
`default_nettype none

module rhc_round (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  up_valid,
    output logic                 up_stall,
    input  rhc_pkg::rhc_div_t    up_word,
    output logic                 dn_valid,
    input  wire                  dn_stall,
    output rhc_pkg::rhc_out_t    dn_word
);
    import rhc_pkg::*;

    logic        valid_reg;
    rhc_out_t    word_reg;
    rhc_out_t    word_next;
    logic [16:0] hue_inc, sat_inc;
    logic [15:0] hue_half, hue_wrap;

    always_comb
    begin
        hue_inc  = {1'b0, up_word.hue_bits} + 17'd1;
        sat_inc  = {1'b0, up_word.sat_bits} + 17'd1;
        hue_half = hue_inc[16:1];
        hue_wrap = (hue_half >= HUE_TURN) ? (hue_half - HUE_TURN) : hue_half;
        word_next.lightness_sum = up_word.sum;
        if (up_word.grey)
        begin
            word_next.hue_angle        = '0;
            word_next.saturation_level = '0;
        end
        else
        begin
            word_next.hue_angle        = hue_wrap[14:0];
            word_next.saturation_level = sat_inc[13:1];
        end
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !up_stall)
            word_reg <= word_next;
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

`default_nettype wire

// File: sv/rgb_to_hsl_converter_unit.sv
// rgb_to_hsl_converter_unit: top level, prep stage, chain of division cells
// and output rounding stage. Depends on rhc_pkg, rhc_prep, rhc_div_cell, rhc_round.
//
// Usage:
//   pixel channel: pixel_valid/pixel_stall/pixel carry one RGB word, taken
//   at a clock edge with pixel_valid high and pixel_stall low.
//   hsl channel: hsl_valid/hsl_stall/hsl carry hue (1/64 degree),
//   saturation (Q0.12) and lightness (max + min) for each pixel, in order.
//   Pipeline: one setup stage, 16 division cells (one quotient bit each for
//   hue and saturation) and one rounding stage that is also the output register.
//   Throughput: one word per cycle while the output is not stalled;
//   every stage holds its own word.
//   Stall: a stalled output word holds. Stages behind it keep moving into
//   empty slots; pixel_stall rises only once every stage holds a word.
//   Reset: rst_n clears all stage valid flags; the pipeline comes up empty.
`default_nettype none

module rgb_to_hsl_converter_unit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  pixel_valid,
    output logic                 pixel_stall,
    input  rhc_pkg::rhc_in_t     pixel,
    output logic                 hsl_valid,
    input  wire                  hsl_stall,
    output rhc_pkg::rhc_out_t    hsl
);
    import rhc_pkg::*;

    logic     chain_valid [DIV_STEPS+1];
    logic     chain_stall [DIV_STEPS+1];
    rhc_div_t chain_word  [DIV_STEPS+1];

    rhc_prep u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (pixel_valid),
        .up_stall (pixel_stall),
        .up_word  (pixel),
        .dn_valid (chain_valid[0]),
        .dn_stall (chain_stall[0]),
        .dn_word  (chain_word[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_cell
        rhc_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[i]),
            .up_stall (chain_stall[i]),
            .up_word  (chain_word[i]),
            .dn_valid (chain_valid[i+1]),
            .dn_stall (chain_stall[i+1]),
            .dn_word  (chain_word[i+1])
        );
    end

    rhc_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (chain_valid[DIV_STEPS]),
        .up_stall (chain_stall[DIV_STEPS]),
        .up_word  (chain_word[DIV_STEPS]),
        .dn_valid (hsl_valid),
        .dn_stall (hsl_stall),
        .dn_word  (hsl)
    );

endmodule

`default_nettype wire

// File: sv/rhc_checker.sv
// rhc_checker: port-level assertions for rgb_to_hsl_converter_unit, with bind.
// Depends on rhc_pkg.
`default_nettype none

module rhc_checker (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  pixel_valid,
    input  wire                  pixel_stall,
    input  rhc_pkg::rhc_in_t     pixel,
    input  wire                  hsl_valid,
    input  wire                  hsl_stall,
    input  rhc_pkg::rhc_out_t    hsl
);
    import rhc_pkg::*;

    // stalled pixel word stays up
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel))
        else $error("pixel word dropped or changed under stall");

    // stalled word stays up
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && hsl_stall |=> hsl_valid && $stable(hsl))
        else $error("hsl word dropped or changed under stall");

    // input backs up only behind a stalled output word
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> hsl_valid && hsl_stall)
        else $error("pixel_stall without stalled output");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid |-> ({1'b0, hsl.hue_angle} < HUE_TURN)
                   && (hsl.saturation_level <= 13'd4096)
                   && (hsl.lightness_sum <= 9'd510))
        else $error("hsl field out of range");

    // zero saturation only for grey pixels, which have zero hue
    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_valid && (hsl.saturation_level == 13'd0) |-> hsl.hue_angle == 15'd0)
        else $error("nonzero hue with zero saturation");

endmodule

bind rgb_to_hsl_converter_unit rhc_checker u_rhc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsl_valid   (hsl_valid),
    .hsl_stall   (hsl_stall),
    .hsl         (hsl)
);

`default_nettype wire
